[hw/rtl/pls_pkg.sv]
// ----------------------------------------------------------------------------
// pls_pkg: shared types and constants of the positional list store
// Operation and status codes, cell commands, control states and the
// packed payload types of the input and result channels.
// ----------------------------------------------------------------------------
package pls_pkg;

  // Default number of list cells.
  localparam int DefCapacity = 16;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_INS_POS   = 3'd2,
    MODE_DEL_FRONT = 3'd3,
    MODE_DEL_BACK  = 3'd4,
    MODE_DEL_POS   = 3'd5,
    MODE_READ      = 3'd6
  } mode_t;

  // Status codes of a result.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_op_t;

  // Control states of the block.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  // One input item.
  typedef struct packed {
    logic [2:0]         mode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               last;
    logic [4:0]         length;
  } out_item_t;

endpackage

[hw/rtl/pls_cell.sv]
// ----------------------------------------------------------------------------
// pls_cell: one storage cell of the list chain
// Holds one element and, on a broadcast command, keeps its value, takes
// the new value, or takes the value of its left, right or head neighbor.
// ----------------------------------------------------------------------------
module pls_cell import pls_pkg::*; #(
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  cell_op_t      op,
  input  logic [CW-1:0] idx,
  input  logic [31:0]   value,
  input  logic [31:0]   left_data,
  input  logic [31:0]   right_data,
  input  logic [31:0]   head_data,
  output logic [31:0]   data
);

  localparam logic [CW-1:0] MyIdx = CW'(IDX);

  logic [31:0] data_r;
  logic [31:0] data_nxt;

  // Select the next content of this cell from the command and its place.
  always_comb begin
    data_nxt = data_r;
    unique case (op)
      CELL_HOLD: data_nxt = data_r;
      CELL_INS: begin
        if (MyIdx == idx) begin
          data_nxt = value;
        end else if (MyIdx > idx) begin
          data_nxt = left_data;
        end
      end
      CELL_DEL: begin
        if (MyIdx >= idx) begin
          data_nxt = right_data;
        end
      end
      CELL_ROT: begin
        if (MyIdx < idx) begin
          data_nxt = right_data;
        end else if (MyIdx == idx) begin
          data_nxt = head_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  // Element storage; contents are payload and need no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

[hw/rtl/positional_list_store.sv]
// ----------------------------------------------------------------------------
// positional_list_store: bounded ordered list in a chain of cells
// Insert and delete at front, back or a 1-based position, and read-out.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid, in_stall, in_data) takes one operation per
//   transfer. The result channel (out_valid, out_stall, out_data) returns
//   the results from an output register.
//   Insert, delete, unused mode and read-out of an empty list give one
//   result, registered in the cycle after the input transfer; the next input
//   item can be taken while that result is shown, so such items sustain one
//   per cycle while the receiver takes results.
//   Read-out of a non-empty list gives one result per stored element, one
//   per cycle while the receiver takes them, front first, with last set on
//   the final one. The chain rotates by one cell per result, so a read-out
//   holds the input channel until its last result and leaves the list as it was.
//   While the output register holds a result that is stalled, no input is
//   taken and a read-out pauses; nothing is lost or repeated.
//   Reset empties the list and the output register; cell contents are not
//   cleared, as no cell is read before it is written.
// ----------------------------------------------------------------------------
module positional_list_store import pls_pkg::*; #(
  parameter int CAPACITY = DefCapacity
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW + 1 > 6) ? CW + 1 : 6;
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  // Control registers.
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  // Chain command.
  cell_op_t      cell_op;
  logic [CW-1:0] cell_idx;
  logic [31:0]   cell_data [CAPACITY];

  logic          out_free;
  logic          in_xfer;
  logic [PW-1:0] pos_x;
  logic [PW-1:0] cnt_x;
  status_t       status;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_xfer  = in_valid && !in_stall;
  assign pos_x    = PW'(in_data.position);
  assign cnt_x    = PW'(count_r);

  // Decode the operation, drive the chain and load the output register.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    rd_cnt_nxt    = rd_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    cell_op       = CELL_HOLD;
    cell_idx      = '0;
    status        = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          unique case (mode_t'(in_data.mode))
            MODE_INS_FRONT, MODE_INS_BACK: begin
              if (count_r == CapCount) begin
                status = ST_FULL;
              end else begin
                cell_op   = CELL_INS;
                cell_idx  = (mode_t'(in_data.mode) == MODE_INS_FRONT) ? '0 : count_r;
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_INS_POS: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x + 1'b1) begin
                status = ST_RANGE;
              end else if (count_r == CapCount) begin
                status = ST_FULL;
              end else begin
                cell_op   = CELL_INS;
                cell_idx  = CW'(pos_x - 1'b1);
                count_nxt = count_r + 1'b1;
              end
            end
            MODE_DEL_FRONT, MODE_DEL_BACK: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end else begin
                cell_op   = CELL_DEL;
                cell_idx  = (mode_t'(in_data.mode) == MODE_DEL_FRONT) ? '0
                                                                      : count_r - 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_DEL_POS: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end else if (pos_x == '0 || pos_x > cnt_x) begin
                status = ST_RANGE;
              end else begin
                cell_op   = CELL_DEL;
                cell_idx  = CW'(pos_x - 1'b1);
                count_nxt = count_r - 1'b1;
              end
            end
            MODE_READ: begin
              if (count_r == '0) begin
                status = ST_EMPTY;
              end
            end
            default: status = ST_OK;
          endcase

          if (mode_t'(in_data.mode) == MODE_READ && count_r != '0) begin
            // Non-empty read-out streams from the head cell.
            state_nxt  = S_READ;
            rd_cnt_nxt = '0;
          end else begin
            out_valid_nxt        = 1'b1;
            out_data_nxt.status  = status;
            out_data_nxt.element = '0;
            out_data_nxt.last    = 1'b1;
            out_data_nxt.length  = 5'(count_nxt);
          end
        end
      end
      S_READ: begin
        if (out_free) begin
          // Emit the head element and rotate the occupied cells by one.
          cell_op              = CELL_ROT;
          cell_idx             = count_r - 1'b1;
          out_valid_nxt        = 1'b1;
          out_data_nxt.status  = ST_OK;
          out_data_nxt.element = cell_data[0];
          out_data_nxt.last    = (rd_cnt_r == count_r - 1'b1);
          out_data_nxt.length  = 5'(count_r);
          rd_cnt_nxt           = rd_cnt_r + 1'b1;
          if (rd_cnt_r == count_r - 1'b1) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, count, read counter and output valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Chain of cells, each linked to its neighbors and to the head cell.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [31:0] left_d;
    logic [31:0] right_d;

    if (g == 0) begin : g_first
      assign left_d = cell_data[g];
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end

    if (g == CAPACITY - 1) begin : g_final
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end

    pls_cell #(
      .CW  (CW),
      .IDX (g)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .idx        (cell_idx),
      .value      (in_data.value),
      .left_data  (left_d),
      .right_data (right_d),
      .head_data  (cell_data[0]),
      .data       (cell_data[g])
    );
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the positional list store
// Sends a directed set of operations and then epochs of random fill, drain
// and mixed traffic. Expected results are predicted for every accepted
// transfer and checked field by field. Both channels idle at random, and
// the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import pls_pkg::*;

  localparam int Cap = DefCapacity;
  localparam logic [2:0] ModeUnused = 3'd7;
  localparam int LongHoldCycles = 300;
  localparam int CalmTailItems = 40;
  localparam int RandomItems = 255;
  localparam int MaxErrorLines = 40;

  // Contents of the list as the bench sees it.
  typedef struct packed {
    logic [Cap-1:0][31:0] cells;
    logic [4:0]           count;
  } list_t;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  in_item_t  pending_ops[$];
  out_item_t expected_results[$];
  list_t     stimulus_list;
  list_t     predicted_list;
  int        total_ops;
  int        ops_accepted;
  int        results_seen;
  int        error_count;
  int        cycle_count;
  int        send_gap;
  int        stall_left;
  int        hold_left;
  bit        hold_done;

  positional_list_store #(
    .CAPACITY(Cap)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

  // Applies one operation to a list and, when asked, queues the results it gives.
  function automatic void apply_list_op(inout list_t l, input in_item_t op, input bit record);
    int        n;
    int        p;
    int        idx;
    int        i;
    bit        do_ins;
    bit        do_del;
    status_t   st;
    out_item_t r;
    n = int'(l.count);
    p = int'(op.position);
    st = ST_OK;
    do_ins = 1'b0;
    do_del = 1'b0;
    idx = 0;
    case (op.mode)
      MODE_INS_FRONT, MODE_INS_BACK: begin
        if (n >= Cap) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx = (op.mode == MODE_INS_FRONT) ? 0 : n;
        end
      end
      MODE_INS_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (p < 1 || p > n + 1) st = ST_RANGE;
        else if (n >= Cap) st = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx = p - 1;
        end
      end
      MODE_DEL_FRONT, MODE_DEL_BACK: begin
        if (n == 0) st = ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx = (op.mode == MODE_DEL_FRONT) ? 0 : n - 1;
        end
      end
      MODE_DEL_POS: begin
        if (n == 0) st = ST_EMPTY;
        else if (p < 1 || p > n) st = ST_RANGE;
        else begin
          do_del = 1'b1;
          idx = p - 1;
        end
      end
      MODE_READ: begin
        // A read-out walks the list front first; an empty list answers once.
        if (record) begin
          if (n == 0) begin
            r.status = ST_EMPTY;
            r.element = '0;
            r.last = 1'b1;
            r.length = '0;
            expected_results.push_back(r);
          end else begin
            for (i = 0; i < n; i++) begin
              r.status = ST_OK;
              r.element = l.cells[i];
              r.last = (i == n - 1);
              r.length = l.count;
              expected_results.push_back(r);
            end
          end
        end
        return;
      end
      default: ;
    endcase

    // Cells behind the touched place move by one.
    if (do_ins) begin
      for (i = Cap - 1; i > idx; i--) l.cells[i] = l.cells[i-1];
      l.cells[idx] = op.value;
      l.count = l.count + 5'd1;
    end
    if (do_del) begin
      for (i = idx; i < Cap - 1; i++) l.cells[i] = l.cells[i+1];
      l.count = l.count - 5'd1;
    end
    if (record) begin
      r.status = st;
      r.element = '0;
      r.last = 1'b1;
      r.length = l.count;
      expected_results.push_back(r);
    end
  endfunction

  // Queues one operation and tracks the list it leaves behind.
  task automatic queue_op(input logic [2:0] mode, input int pos, input logic [31:0] value);
    in_item_t op;
    op.mode = mode;
    op.position = pos[4:0];
    op.value = value;
    apply_list_op(stimulus_list, op, 1'b0);
    pending_ops.push_back(op);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Idling stops near the end of the run and pauses in every third window.
  function automatic bit idling_allowed();
    return pending_ops.size() > CalmTailItems && ((cycle_count / 150) % 3 != 2);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MaxErrorLines) $display("ERROR at %0t: %s", $time, what);
    error_count++;
  endtask

  // Stimulus, reset and the end of the run.
  initial begin
    int epoch_left;
    int epoch_kind;
    int roll;
    int ins_share;
    int n;
    int k;
    stimulus_list = '0;
    predicted_list = '0;

    // Directed part: empty-list requests, each insert and delete form,
    // positions at and beyond both ends, the unused mode and emptying a
    // one-element list.
    queue_op(MODE_READ, 0, 32'h0);
    queue_op(MODE_DEL_FRONT, 0, 32'h0);
    queue_op(MODE_DEL_BACK, 0, 32'h0);
    queue_op(MODE_DEL_POS, 1, 32'h0);
    queue_op(MODE_INS_POS, 1, 32'h1111_1111);
    queue_op(MODE_INS_FRONT, 0, 32'h7fff_ffff);
    queue_op(MODE_INS_BACK, 0, 32'h8000_0000);
    queue_op(MODE_INS_POS, 1, 32'hffff_ffff);
    queue_op(MODE_INS_POS, 4, 32'h0000_0000);
    queue_op(MODE_INS_POS, 0, 32'h2222_2222);
    queue_op(MODE_INS_POS, 31, 32'h3333_3333);
    queue_op(MODE_INS_POS, 6, 32'h4444_4444);
    queue_op(MODE_READ, 0, 32'h0);
    queue_op(MODE_DEL_POS, 0, 32'h0);
    queue_op(MODE_DEL_POS, 5, 32'h0);
    queue_op(MODE_DEL_POS, 2, 32'h0);
    queue_op(MODE_DEL_FRONT, 0, 32'h0);
    queue_op(MODE_DEL_BACK, 0, 32'h0);
    queue_op(ModeUnused, 31, 32'h5555_aaaa);
    queue_op(MODE_READ, 0, 32'h0);
    queue_op(MODE_DEL_POS, 1, 32'h0);
    queue_op(MODE_READ, 0, 32'h0);
    queue_op(MODE_INS_BACK, 0, 32'h1234_5678);
    queue_op(MODE_DEL_BACK, 0, 32'h0);

    // Random part in epochs that fill, drain or mix, so the list reaches
    // full and empty repeatedly. A few items are pure noise.
    epoch_left = 0;
    epoch_kind = 0;
    for (k = 0; k < RandomItems; k++) begin
      if (epoch_left == 0) begin
        epoch_kind = $urandom_range(0, 2);
        epoch_left = $urandom_range(15, 35);
      end
      epoch_left--;
      n = int'(stimulus_list.count);
      ins_share = (epoch_kind == 0) ? 70 : (epoch_kind == 1) ? 15 : 40;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        queue_op(3'($urandom_range(0, 7)), $urandom_range(0, 31), $urandom);
      end else if (roll < 16) begin
        queue_op(MODE_READ, $urandom_range(0, 31), $urandom);
      end else if (roll < 16 + ins_share) begin
        case ($urandom_range(0, 2))
          0: queue_op(MODE_INS_FRONT, $urandom_range(0, 31), pick_value());
          1: queue_op(MODE_INS_BACK, $urandom_range(0, 31), pick_value());
          default: queue_op(MODE_INS_POS, $urandom_range(1, n + 1), pick_value());
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: queue_op(MODE_DEL_FRONT, $urandom_range(0, 31), $urandom);
          1: queue_op(MODE_DEL_BACK, $urandom_range(0, 31), $urandom);
          default: queue_op(MODE_DEL_POS, $urandom_range(1, (n > 0) ? n : 1), $urandom);
        endcase
      end
    end
    total_ops = pending_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (ops_accepted < total_ops || expected_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Driver: predicts each accepted transfer, then offers the next operation
  // or a gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
      ops_accepted <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_op(predicted_list, in_data, 1'b1);
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
          in_valid <= 1'b0;
          send_gap <= $urandom_range(0, 13);
        end else if (pending_ops.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transfer and drives the result-side stall.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      results_seen <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %p", out_data));
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.element !== want.element)
            report_mismatch($sformatf("element %0h, expected %0h",
                                      out_data.element, want.element));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b",
                                      out_data.last, want.last));
          if (out_data.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d",
                                      out_data.length, want.length));
        end
      end

      // One long hold-off fills the block; otherwise stall in short bursts.
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && results_seen >= 40) begin
        out_stall <= 1'b1;
        hold_left <= LongHoldCycles - 1;
        hold_done <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 13);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

endmodule
